// File: design/thermal_false_color_autorange_unit_macros.svh
// Assertion macros shared by the thermal false color design.
`ifndef THERMAL_FALSE_COLOR_AUTORANGE_UNIT_MACROS_SVH
`define THERMAL_FALSE_COLOR_AUTORANGE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFCA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/tfca_pkg.sv
package tfca_pkg;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	localparam int STOP_COUNT = 5;

	localparam logic [7:0] STOP_RED   [STOP_COUNT] = '{8'd0, 8'd32, 8'd204, 8'd255, 8'd255};
	localparam logic [7:0] STOP_GREEN [STOP_COUNT] = '{8'd0, 8'd0, 8'd0, 8'd221, 8'd255};
	localparam logic [7:0] STOP_BLUE  [STOP_COUNT] = '{8'd0, 8'd140, 8'd119, 8'd0, 8'd255};

	localparam logic [7:0] LEVEL_FULL = 8'hFF;

	function automatic logic [7:0] stop_level(input logic [2:0] stop, input logic [1:0] chan);
		logic [7:0] level;
		level = 8'd0;
		if (stop < 3'(STOP_COUNT)) begin
			case (chan)
				CH_RED:   level = STOP_RED[stop];
				CH_GREEN: level = STOP_GREEN[stop];
				CH_BLUE:  level = STOP_BLUE[stop];
				default:  level = 8'd0;
			endcase
		end
		return level;
	endfunction

endpackage

// File: design/tfca_pixel_if.sv
interface tfca_pixel_if #(parameter int TEMP_BITS = 16);
	logic                        valid;
	logic                        ready;
	logic signed [TEMP_BITS-1:0] temperature;
	logic                        frame_end;

	modport source (output valid, output temperature, output frame_end, input ready);
	modport sink (input valid, input temperature, input frame_end, output ready);
endinterface

// File: design/tfca_color_if.sv
interface tfca_color_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// File: design/tfca_div.sv
`include "thermal_false_color_autorange_unit_macros.svh"

module tfca_div #(
	parameter int TEMP_BITS = 16,
	parameter int QUO_BITS  = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [TEMP_BITS-1:0]  dividend,
	input  logic [TEMP_BITS-1:0]  divisor,
	output tfca_pkg::div_stat_t   stat,
	output logic [QUO_BITS-1:0]   quotient
);
	import tfca_pkg::*;

	localparam int CNT_BITS = $clog2(QUO_BITS + 1);

	logic [TEMP_BITS:0]   rem_q;
	logic [TEMP_BITS-1:0] divisor_q;
	logic [QUO_BITS-1:0]  quo_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [TEMP_BITS:0] shifted;
	logic               fits;

	assign shifted = {rem_q[TEMP_BITS-1:0], 1'b0};
	assign fits    = shifted >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(QUO_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= {1'b0, dividend};
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, divisor_q}) : shifted;
			quo_q <= {quo_q[QUO_BITS-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	`TFCA_ASSERT_IMP(a_rem_below_divisor, clk, arst_n, busy_q, rem_q < {1'b0, divisor_q}, "Partial remainder reached the divisor.")
	`TFCA_ASSERT_NXT(a_start_busy, clk, arst_n, start, busy_q, "Divider did not start.")
	`TFCA_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, !busy_q, "Divider reported done while busy.")

endmodule

// File: design/tfca_color.sv
module tfca_color #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                     white,
	input  logic [FRACTION_BITS+1:0] pos,
	output tfca_pkg::rgb_t           rgb
);
	import tfca_pkg::*;

	logic [1:0]               seg;
	logic [FRACTION_BITS-1:0] frac;
	logic [2:0][7:0]          levels;

	assign seg  = pos[FRACTION_BITS+1:FRACTION_BITS];
	assign frac = pos[FRACTION_BITS-1:0];

	for (genvar g = 0; g < 3; g++) begin : g_chan
		logic [7:0]                      lo;
		logic [7:0]                      hi;
		logic signed [8:0]               diff;
		logic signed [FRACTION_BITS+9:0] prod;
		logic signed [FRACTION_BITS+9:0] step;

		assign lo   = stop_level({1'b0, seg}, 2'(g));
		assign hi   = stop_level({1'b0, seg} + 3'd1, 2'(g));
		assign diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
		assign prod = (FRACTION_BITS+10)'(diff) *
			(FRACTION_BITS+10)'($signed({1'b0, frac}));
		assign step = prod >>> FRACTION_BITS;
		assign levels[g] = white ? LEVEL_FULL : (lo + step[7:0]);
	end

	assign rgb.red   = levels[CH_RED];
	assign rgb.green = levels[CH_GREEN];
	assign rgb.blue  = levels[CH_BLUE];

endmodule

// File: design/thermal_false_color_autorange_unit.sv
// Thermal false color mapper with automatic range.
// The pixel channel carries one signed temperature per item together with a
// flag that marks the last pixel of a frame. The color channel returns one
// RGB item for every pixel, in order, on a five-stop gradient scaled to the
// minimum and maximum of the previous frame.
// A pixel inside the scale runs through a bit-serial divider that yields one
// quotient bit per cycle. Its quotient is registered as the blend position
// when the divider is done, and the blended color is then loaded into the
// output register. A pixel at or outside the scale skips the divider and goes
// straight to the output register. In both cases the next pixel is accepted
// only once the current one has been loaded into the output register.
// Reset sets the scale to zero through 3200 and restarts the frame
// minimum and maximum. The output register holds a finished item while the
// receiver stalls; the block then finishes the next pixel and waits with it
// until the register is free.
`include "thermal_false_color_autorange_unit_macros.svh"

module thermal_false_color_autorange_unit #(
	parameter int TEMP_BITS     = 16,
	parameter int FRACTION_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	tfca_pixel_if.sink  pixel,
	tfca_color_if.source color
);
	import tfca_pkg::*;

	localparam int QUO_BITS = FRACTION_BITS + 2;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	localparam logic signed [TEMP_BITS-1:0] PEAK_INIT  = {1'b1, {(TEMP_BITS-1){1'b0}}};
	localparam logic signed [TEMP_BITS-1:0] FLOOR_INIT = {1'b0, {(TEMP_BITS-1){1'b1}}};
	localparam logic signed [TEMP_BITS-1:0] TOP_INIT   = TEMP_BITS'(3200);

	logic [1:0] state_q;

	logic signed [TEMP_BITS-1:0] top_q;
	logic signed [TEMP_BITS-1:0] bottom_q;
	logic signed [TEMP_BITS-1:0] peak_q;
	logic signed [TEMP_BITS-1:0] floor_q;

	logic [QUO_BITS-1:0] pos_q;
	logic                white_q;
	logic                out_valid_q;
	rgb_t                out_q;

	logic                        accept;
	logic signed [TEMP_BITS-1:0] t;
	logic signed [TEMP_BITS-1:0] new_peak;
	logic signed [TEMP_BITS-1:0] new_floor;
	logic [TEMP_BITS-1:0]        span_pixel;
	logic [TEMP_BITS-1:0]        span_scale;
	logic                        below;
	logic                        above;
	logic                        div_start;
	logic                        load_out;
	div_stat_t                   div_stat;
	logic [QUO_BITS-1:0]         quotient;
	rgb_t                        blend;

	assign t          = pixel.temperature;
	assign accept     = pixel.valid && pixel.ready;
	assign new_peak   = (t > peak_q) ? t : peak_q;
	assign new_floor  = (t < floor_q) ? t : floor_q;
	assign span_pixel = t - bottom_q;
	assign span_scale = top_q - bottom_q;
	assign below      = t <= bottom_q;
	assign above      = (top_q <= bottom_q) || (t >= top_q);
	assign div_start  = accept && !below && !above;
	assign load_out   = (state_q == S_OUT) && (!out_valid_q || color.ready);

	assign pixel.ready = state_q == S_IDLE;

	tfca_div #(
		.TEMP_BITS (TEMP_BITS),
		.QUO_BITS  (QUO_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (span_pixel),
		.divisor  (span_scale),
		.stat     (div_stat),
		.quotient (quotient)
	);

	tfca_color #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_color (
		.white (white_q),
		.pos   (pos_q),
		.rgb   (blend)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			top_q    <= TOP_INIT;
			bottom_q <= '0;
			peak_q   <= PEAK_INIT;
			floor_q  <= FLOOR_INIT;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= div_start ? S_DIV : S_OUT;
						if (pixel.frame_end) begin
							top_q    <= new_peak;
							bottom_q <= new_floor;
							peak_q   <= PEAK_INIT;
							floor_q  <= FLOOR_INIT;
						end else begin
							peak_q  <= new_peak;
							floor_q <= new_floor;
						end
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			white_q <= above && !below;
			pos_q   <= '0;
		end else if ((state_q == S_DIV) && div_stat.done) begin
			pos_q <= quotient;
		end
		if (load_out) begin
			out_q <= blend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (color.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign color.valid = out_valid_q;
	assign color.red   = out_q.red;
	assign color.green = out_q.green;
	assign color.blue  = out_q.blue;

	`TFCA_ASSERT_IMP(a_div_owned, clk, arst_n, state_q == S_DIV, div_stat.busy || div_stat.done, "Waiting on an idle divider.")
	`TFCA_ASSERT_IMP(a_done_in_div, clk, arst_n, div_stat.done, state_q == S_DIV, "Divider finished outside the divide state.")
	`TFCA_ASSERT_NXT(a_frame_restart, clk, arst_n, accept && pixel.frame_end, (peak_q == PEAK_INIT) && (floor_q == FLOOR_INIT), "Frame tracking did not restart.")

endmodule
